// ===== src/fdq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdq_pkg
// Shared types and constants for the frame admission queue with
// duplicate suppression and deferred flush.
// ----------------------------------------------------------------------------
package fdq_pkg;

  // Default number of ring slots (the queue holds at most DEPTH-1 frames)
  localparam int DepthDefault = 16;

  // Width of the free-running head, tail and flush counters
  localparam int CntW = 16;

  // Value of the last accepted seq/cmd pair after reset
  localparam logic [7:0] LastInit = 8'hFF;

  // Item kinds
  localparam logic KindReceive = 1'b0;
  localparam logic KindProcess = 1'b1;

  // Configuration register indexes
  localparam logic CfgQueueMode   = 1'b0;
  localparam logic CfgResetOpcode = 1'b1;

  typedef enum logic [2:0] {
    StDup        = 3'd0,
    StInline     = 3'd1,
    StQueued     = 3'd2,
    StDropped    = 3'd3,
    StDispatched = 3'd4,
    StEmpty      = 3'd5
  } status_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  seq;
    logic [7:0]  cmd;
    logic [63:0] payload;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  out_seq;
    logic [7:0]  out_cmd;
    logic [63:0] out_payload;
    logic        flush_applied;
    logic [3:0]  queue_count;
  } result_t;

endpackage

// ===== src/frame_dedup_queue_with_flush.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_dedup_queue_with_flush
// Command frame admission queue: duplicate suppression, inline dispatch,
// bounded ring FIFO and a deferred flush on reset commands.
// ----------------------------------------------------------------------------
// Usage: the block takes one request in every clock cycle (busy is always
// low) and returns exactly one result for each request, on the result port
// with done high for a single cycle, in the cycle after the request was taken.
// The receiver cannot stall, and none is needed: each request is settled by
// its compares and at most one ring memory write or read in the cycle it
// arrives, and the ring read data register feeds the result in the next cycle.
// The ring memory is not cleared after reset; only its head, tail and flush
// counters are. Configuration writes are taken at any edge with cfg_wr_en
// high, and must only be issued while no request is in flight.
// ----------------------------------------------------------------------------
module frame_dedup_queue_with_flush #(
  parameter int DEPTH = fdq_pkg::DepthDefault
) (
  input  logic            clk,
  input  logic            rst,
  // request side
  input  logic            start,
  output logic            busy,
  input  fdq_pkg::item_t  item,
  // result side
  output logic            done,
  output fdq_pkg::result_t result,
  // configuration write port
  input  logic            cfg_wr_en,
  input  logic            cfg_index,
  input  logic [7:0]      cfg_data
);

  localparam int SlotW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW  = fdq_pkg::CntW;
  localparam logic [CntW-1:0]  DepthCnt = CntW'(DEPTH);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(DEPTH - 1);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(DEPTH - 1);
  localparam logic [CntW-1:0]  CntMax   = {CntW{1'b1}};

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic       queue_mode;
  logic [7:0] reset_opcode;

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_mode   <= 1'b0;
      reset_opcode <= 8'd0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        fdq_pkg::CfgQueueMode:   queue_mode   <= cfg_data[0];
        fdq_pkg::CfgResetOpcode: reset_opcode <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Queue state. Each counter carries its slot (counter mod DEPTH) alongside,
  // advanced incrementally and forced to zero when the counter wraps.
  // --------------------------------------------------------------------------
  logic [7:0]      last_seq_seen, last_seq_seen_next;
  logic [7:0]      last_cmd_seen, last_cmd_seen_next;
  logic [CntW-1:0] head_count, head_count_next;
  logic [CntW-1:0] tail_count, tail_count_next;
  logic [CntW-1:0] flush_point, flush_point_next;
  logic            flush_pending, flush_pending_next;
  logic [SlotW-1:0] head_slot, head_slot_next;
  logic [SlotW-1:0] tail_slot, tail_slot_next;
  logic [SlotW-1:0] flush_slot, flush_slot_next;

  // Ring memory: body word and header (seq, cmd)
  logic [63:0] frame_store  [DEPTH];
  logic [15:0] header_store [DEPTH];
  logic [63:0] rd_frame;
  logic [15:0] rd_header;

  // Per-request decisions
  logic            accept;
  logic            is_dup;
  logic            is_reset;
  logic            queue_empty;
  logic [CntW-1:0] held;
  logic            flush_ok;
  logic            applied;
  logic [CntW-1:0] tail_eff;
  logic [SlotW-1:0] slot_eff;
  logic            wr_en;
  logic            rd_en;
  fdq_pkg::status_t status_next;
  logic            inline_next;

  // Result register
  logic             res_from_queue;
  logic             res_inline;
  fdq_pkg::status_t res_status;
  logic             res_applied;
  logic [3:0]       res_count;
  logic [7:0]       res_seq;
  logic [7:0]       res_cmd;
  logic [63:0]      res_payload;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  function automatic logic [SlotW-1:0] slot_inc(input logic [SlotW-1:0] slot,
                                                input logic [CntW-1:0]  cnt);
    logic [SlotW-1:0] nxt;
    nxt = (slot == LastSlot) ? '0 : slot + SlotW'(1);
    if (cnt == CntMax) begin
      nxt = '0;
    end
    return nxt;
  endfunction

  always_comb begin
    is_dup      = (item.seq == last_seq_seen) && (item.cmd == last_cmd_seen);
    is_reset    = (item.cmd == reset_opcode);
    queue_empty = (tail_count == head_count);
    held        = head_count - tail_count;
    flush_ok    = (CntW'(flush_point - tail_count) < DepthCnt);
    applied     = flush_pending & flush_ok;
    // tail after a pending flush that is in range, used by a process request
    tail_eff    = applied ? flush_point : tail_count;
    slot_eff    = applied ? flush_slot  : tail_slot;
  end

  always_comb begin
    last_seq_seen_next = last_seq_seen;
    last_cmd_seen_next = last_cmd_seen;
    head_count_next    = head_count;
    tail_count_next    = tail_count;
    flush_point_next   = flush_point;
    flush_pending_next = flush_pending;
    head_slot_next     = head_slot;
    tail_slot_next     = tail_slot;
    flush_slot_next    = flush_slot;
    wr_en              = 1'b0;
    rd_en              = 1'b0;
    inline_next        = 1'b0;
    status_next        = fdq_pkg::StDup;

    if (item.kind == fdq_pkg::KindReceive) begin
      if (is_dup) begin
        status_next = fdq_pkg::StDup;
      end else begin
        // record the current head as the flush point
        if (is_reset) begin
          flush_point_next   = head_count;
          flush_slot_next    = head_slot;
          flush_pending_next = 1'b1;
        end
        if (is_reset || (queue_mode && queue_empty)) begin
          status_next        = fdq_pkg::StInline;
          inline_next        = 1'b1;
          last_seq_seen_next = item.seq;
          last_cmd_seen_next = item.cmd;
        end else if (held >= FullCnt) begin
          status_next = fdq_pkg::StDropped;
        end else begin
          status_next        = fdq_pkg::StQueued;
          wr_en              = 1'b1;
          head_count_next    = head_count + CntW'(1);
          head_slot_next     = slot_inc(head_slot, head_count);
          last_seq_seen_next = item.seq;
          last_cmd_seen_next = item.cmd;
        end
      end
    end else begin
      // drop the pending flush whether or not it moves the tail
      flush_pending_next = 1'b0;
      tail_count_next    = tail_eff;
      tail_slot_next     = slot_eff;
      if (tail_eff == head_count) begin
        status_next = fdq_pkg::StEmpty;
      end else begin
        status_next     = fdq_pkg::StDispatched;
        rd_en           = 1'b1;
        tail_count_next = tail_eff + CntW'(1);
        tail_slot_next  = slot_inc(slot_eff, tail_eff);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_seq_seen <= fdq_pkg::LastInit;
      last_cmd_seen <= fdq_pkg::LastInit;
      head_count    <= '0;
      tail_count    <= '0;
      flush_point   <= '0;
      flush_pending <= 1'b0;
      head_slot     <= '0;
      tail_slot     <= '0;
      flush_slot    <= '0;
    end else if (accept) begin
      last_seq_seen <= last_seq_seen_next;
      last_cmd_seen <= last_cmd_seen_next;
      head_count    <= head_count_next;
      tail_count    <= tail_count_next;
      flush_point   <= flush_point_next;
      flush_pending <= flush_pending_next;
      head_slot     <= head_slot_next;
      tail_slot     <= tail_slot_next;
      flush_slot    <= flush_slot_next;
    end
  end

  // Ring memory write at the head, registered read at the (flushed) tail
  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      frame_store[head_slot]  <= item.payload;
      header_store[head_slot] <= {item.seq, item.cmd};
    end
  end

  always_ff @(posedge clk) begin
    if (accept && rd_en) begin
      rd_frame  <= frame_store[slot_eff];
      rd_header <= header_store[slot_eff];
    end
  end

  // --------------------------------------------------------------------------
  // Result register: done and source flags reset, other fields hold
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      done           <= 1'b0;
      res_from_queue <= 1'b0;
      res_inline     <= 1'b0;
    end else begin
      done           <= accept;
      res_from_queue <= accept & rd_en;
      res_inline     <= accept & inline_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_status  <= status_next;
      res_applied <= (item.kind == fdq_pkg::KindProcess) & applied;
      res_count   <= 4'(head_count_next - tail_count_next);
      res_seq     <= item.seq;
      res_cmd     <= item.cmd;
      res_payload <= item.payload;
    end
  end

  // Select the dispatched frame: from the ring read register or the request, else zero
  always_comb begin
    result.status        = res_status;
    result.flush_applied = res_applied;
    result.queue_count   = res_count;
    if (res_from_queue) begin
      result.out_seq     = rd_header[15:8];
      result.out_cmd     = rd_header[7:0];
      result.out_payload = rd_frame;
    end else if (res_inline) begin
      result.out_seq     = res_seq;
      result.out_cmd     = res_cmd;
      result.out_payload = res_payload;
    end else begin
      result.out_seq     = 8'd0;
      result.out_cmd     = 8'd0;
      result.out_payload = 64'd0;
    end
  end

endmodule
